// ===== rtl/core/pattern_data_decompressor_core_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef PATTERN_DATA_DECOMPRESSOR_CORE_MACROS_SVH
`define PATTERN_DATA_DECOMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define PDD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdd check failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define PDD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdd check failed");

`endif

// ===== rtl/core/pdd_pkg.sv =====
package pdd_pkg;

  localparam int BLOCK_DEPTH = 256;
  localparam int IDX_W = $clog2(BLOCK_DEPTH + 1);
  localparam int ADDR_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam logic [31:0] DEPTH_LIMIT = 32'(BLOCK_DEPTH);

  localparam logic [1:0] CMD_OFFER  = 2'd0;
  localparam logic [1:0] CMD_PULL   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [2:0] OP_ZERO    = 3'd0;
  localparam logic [2:0] OP_LITERAL = 3'd1;
  localparam logic [2:0] OP_REPEAT  = 3'd2;
  localparam logic [2:0] OP_COMMON  = 3'd3;
  localparam logic [2:0] OP_ZRUN    = 3'd4;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_BAD_OP   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       byte_taken;
    logic       more_pending;
    logic [2:0] status;
  } rsp_t;

endpackage

// ===== rtl/core/pdd_in_reg.sv =====
module pdd_in_reg import pdd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  input  logic take,
  output logic held_valid,
  output req_t held
);

  assign req_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ready) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      held <= req;
    end
  end

endmodule

// ===== rtl/core/pdd_out_reg.sv =====
module pdd_out_reg import pdd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  rsp_t rsp_d,
  output logic space,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  assign space = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (space) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_d;
    end
  end

endmodule

// ===== rtl/core/pdd_engine.sv =====
module pdd_engine import pdd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t req_q,
  output rsp_t rsp_d
);

  typedef enum logic [3:0] {
    PH_OPCODE,
    PH_COUNT,
    PH_ARG1,
    PH_ARG2,
    PH_LITERAL,
    PH_LOAD,
    PH_CUSTOM,
    PH_REPLAY,
    PH_ZEROS
  } phase_t;

  // Outcome of the end-of-piece sequencing that follows a block, run or custom.
  typedef struct packed {
    phase_t      phase;
    logic        sl_we;
    logic [31:0] sl_val;
    logic        pend_we;
    logic [31:0] pend_val;
    logic        cp_one;
    logic        idx_clr;
    logic        acc_clr;
    logic        too_long;
  } flow_t;

  phase_t            phase, phase_next;
  logic [2:0]        op, op_next;
  logic [31:0]       run_length, run_length_next;
  logic [31:0]       varint_acc, varint_acc_next;
  logic [31:0]       custom_length, custom_length_next;
  logic [31:0]       sections_left, sections_left_next;
  logic [31:0]       copies_left, copies_left_next;
  logic [IDX_W-1:0]  store_index, store_index_next;
  logic [31:0]       pending_left, pending_left_next;
  logic [2:0]        fault, fault_next;

  logic [7:0]        block_store [BLOCK_DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              mem_we;

  flow_t             f;
  logic              use_f;
  logic              pending;
  logic [31:0]       acc_shift;
  logic [31:0]       pend_dec;
  logic [31:0]       cp_dec;
  logic [IDX_W-1:0]  idx_inc;
  logic              o_valid, o_taken;
  logic [7:0]        o_byte;

  function automatic flow_t after_block(logic [2:0] fop, logic [31:0] rl,
                                        logic [31:0] cl, logic [31:0] sl);
    flow_t r;
    r = '0;
    r.phase = PH_OPCODE;
    if ((fop == OP_COMMON || fop == OP_ZRUN) && sl != 32'd0) begin
      r.sl_we = 1'b1;
      if (cl == 32'd0 && rl == 32'd0) begin
        // nothing left to emit: drop the remaining sections
        r.sl_val = 32'd0;
      end else begin
        r.sl_val = sl - 32'd1;
        if (cl != 32'd0) begin
          r.pend_we  = 1'b1;
          r.pend_val = cl;
          r.phase    = PH_CUSTOM;
        end else if (fop == OP_ZRUN) begin
          r.pend_we  = 1'b1;
          r.pend_val = rl;
          r.phase    = PH_ZEROS;
        end else begin
          r.cp_one  = 1'b1;
          r.idx_clr = 1'b1;
          r.phase   = PH_REPLAY;
        end
      end
    end
    return r;
  endfunction

  function automatic flow_t begin_zeros(logic [2:0] fop, logic [31:0] rl,
                                        logic [31:0] cl, logic [31:0] sl);
    flow_t r;
    r = after_block(fop, rl, cl, sl);
    if (rl != 32'd0) begin
      r = '0;
      r.pend_we  = 1'b1;
      r.pend_val = rl;
      r.phase    = PH_ZEROS;
    end
    return r;
  endfunction

  function automatic flow_t after_custom(logic [2:0] fop, logic [31:0] rl,
                                         logic [31:0] cl, logic [31:0] sl);
    flow_t r;
    r = begin_zeros(fop, rl, cl, sl);
    if (fop != OP_ZRUN && rl != 32'd0) begin
      r = '0;
      r.cp_one  = 1'b1;
      r.idx_clr = 1'b1;
      r.phase   = PH_REPLAY;
    end
    return r;
  endfunction

  function automatic flow_t after_load(logic [2:0] fop, logic [31:0] rl, logic [31:0] cl,
                                       logic [31:0] sl, logic [31:0] cp);
    flow_t r;
    r = after_block(fop, rl, cl, sl);
    if (fop == OP_REPEAT && cp != 32'd0 && rl != 32'd0) begin
      r = '0;
      r.idx_clr = 1'b1;
      r.phase   = PH_REPLAY;
    end
    return r;
  endfunction

  function automatic flow_t begin_load(logic [2:0] fop, logic [31:0] rl, logic [31:0] cl,
                                       logic [31:0] sl, logic [31:0] cp);
    flow_t r;
    r = '0;
    r.phase = PH_LOAD;
    if (rl == 32'd0) begin
      r = after_load(fop, rl, cl, sl, cp);
    end
    r.idx_clr = 1'b1;
    if (rl > DEPTH_LIMIT) begin
      r.too_long = 1'b1;
    end
    return r;
  endfunction

  function automatic flow_t start_op(logic [2:0] fop, logic [31:0] rl,
                                     logic [31:0] cl, logic [31:0] sl);
    flow_t r;
    r = '0;
    if (fop == OP_ZERO) begin
      r = begin_zeros(fop, rl, cl, sl);
    end else if (fop == OP_LITERAL) begin
      r.pend_we  = 1'b1;
      r.pend_val = rl;
      r.phase    = (rl == 32'd0) ? PH_OPCODE : PH_LITERAL;
    end else begin
      r.acc_clr = 1'b1;
      r.phase   = PH_ARG1;
    end
    return r;
  endfunction

  assign pending   = (phase == PH_REPLAY) || (phase == PH_ZEROS);
  assign acc_shift = {varint_acc[24:0], req_q.in_byte[6:0]};
  assign pend_dec  = pending_left - 32'd1;
  assign cp_dec    = copies_left - 32'd1;
  assign idx_inc   = store_index + IDX_W'(1);

  always_comb begin
    phase_next         = phase;
    op_next            = op;
    run_length_next    = run_length;
    varint_acc_next    = varint_acc;
    custom_length_next = custom_length;
    sections_left_next = sections_left;
    copies_left_next   = copies_left;
    store_index_next   = store_index;
    pending_left_next  = pending_left;
    fault_next         = fault;
    f                  = '0;
    use_f              = 1'b0;
    mem_we             = 1'b0;
    o_valid            = 1'b0;
    o_byte             = 8'd0;
    o_taken            = 1'b0;

    if (fire && fault == ST_RUN) begin
      unique case (req_q.command)
        CMD_OFFER: begin
          if (!pending) begin
            o_taken = 1'b1;
            unique case (phase)
              PH_OPCODE: begin
                if (req_q.in_byte[7:5] > OP_ZRUN) begin
                  fault_next = ST_BAD_OP;
                end else begin
                  op_next            = req_q.in_byte[7:5];
                  sections_left_next = 32'd0;
                  copies_left_next   = 32'd0;
                  if (req_q.in_byte[4:0] == 5'd0) begin
                    varint_acc_next = 32'd0;
                    phase_next      = PH_COUNT;
                  end else begin
                    run_length_next = {27'd0, req_q.in_byte[4:0]};
                    f = start_op(req_q.in_byte[7:5], {27'd0, req_q.in_byte[4:0]},
                                 custom_length, 32'd0);
                    use_f = 1'b1;
                  end
                end
              end
              PH_COUNT, PH_ARG1, PH_ARG2: begin
                if (req_q.in_byte[7]) begin
                  varint_acc_next = acc_shift;
                end else begin
                  varint_acc_next = 32'd0;
                  use_f = 1'b1;
                  if (phase == PH_COUNT) begin
                    run_length_next = acc_shift;
                    f = start_op(op, acc_shift, custom_length, sections_left);
                  end else if (phase == PH_ARG1) begin
                    if (op == OP_REPEAT) begin
                      copies_left_next = acc_shift;
                      f = begin_load(op, run_length, custom_length, sections_left,
                                     acc_shift);
                    end else begin
                      custom_length_next = acc_shift;
                      use_f              = 1'b0;
                      phase_next         = PH_ARG2;
                    end
                  end else begin
                    sections_left_next = acc_shift;
                    if (op == OP_COMMON) begin
                      f = begin_load(op, run_length, custom_length, acc_shift,
                                     copies_left);
                    end else begin
                      f = begin_zeros(op, run_length, custom_length, acc_shift);
                    end
                  end
                end
              end
              PH_LITERAL, PH_CUSTOM: begin
                o_valid           = 1'b1;
                o_byte            = req_q.in_byte;
                pending_left_next = pend_dec;
                if (pend_dec == 32'd0) begin
                  if (phase == PH_LITERAL) begin
                    phase_next = PH_OPCODE;
                  end else begin
                    f     = after_custom(op, run_length, custom_length, sections_left);
                    use_f = 1'b1;
                  end
                end
              end
              PH_LOAD: begin
                mem_we           = 1'b1;
                o_valid          = 1'b1;
                o_byte           = req_q.in_byte;
                store_index_next = idx_inc;
                if (32'(idx_inc) >= run_length) begin
                  f = after_load(op, run_length, custom_length, sections_left,
                                 copies_left);
                  use_f = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_PULL: begin
          if (phase == PH_ZEROS) begin
            o_valid           = 1'b1;
            pending_left_next = pend_dec;
            if (pend_dec == 32'd0) begin
              f     = after_block(op, run_length, custom_length, sections_left);
              use_f = 1'b1;
            end
          end else if (phase == PH_REPLAY) begin
            o_valid          = 1'b1;
            o_byte           = rd_data;
            store_index_next = idx_inc;
            if (32'(idx_inc) >= run_length) begin
              // one copy finished: rewind and count it off
              store_index_next = '0;
              copies_left_next = cp_dec;
              if (cp_dec == 32'd0) begin
                f     = after_block(op, run_length, custom_length, sections_left);
                use_f = 1'b1;
              end
            end
          end
        end
        CMD_FINISH: begin
          if (!pending) begin
            fault_next = (phase == PH_OPCODE) ? ST_DONE : ST_TRUNC;
          end
        end
        default: ;
      endcase
    end

    if (use_f) begin
      phase_next = f.phase;
      if (f.sl_we) begin
        sections_left_next = f.sl_val;
      end
      if (f.pend_we) begin
        pending_left_next = f.pend_val;
      end
      if (f.cp_one) begin
        copies_left_next = 32'd1;
      end
      if (f.idx_clr) begin
        store_index_next = '0;
      end
      if (f.acc_clr) begin
        varint_acc_next = 32'd0;
      end
      if (f.too_long) begin
        fault_next = ST_TOO_LONG;
      end
    end

    rsp_d.status       = fault_next;
    rsp_d.more_pending = (fault_next == ST_RUN) &&
                         (phase_next == PH_REPLAY || phase_next == PH_ZEROS);
    rsp_d.out_valid    = (fault_next == ST_RUN) && o_valid;
    rsp_d.out_byte     = (fault_next == ST_RUN) ? o_byte : 8'd0;
    rsp_d.byte_taken   = (fault_next == ST_RUN) && o_taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_OPCODE;
      op            <= OP_ZERO;
      run_length    <= 32'd0;
      varint_acc    <= 32'd0;
      custom_length <= 32'd0;
      sections_left <= 32'd0;
      copies_left   <= 32'd0;
      store_index   <= '0;
      pending_left  <= 32'd0;
      fault         <= ST_RUN;
    end else begin
      phase         <= phase_next;
      op            <= op_next;
      run_length    <= run_length_next;
      varint_acc    <= varint_acc_next;
      custom_length <= custom_length_next;
      sections_left <= sections_left_next;
      copies_left   <= copies_left_next;
      store_index   <= store_index_next;
      pending_left  <= pending_left_next;
      fault         <= fault_next;
    end
  end

  // Read ahead at the next index so replay data is registered when the pull comes.
  assign wr_addr = store_index[ADDR_W-1:0];
  assign rd_addr = store_index_next[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      block_store[wr_addr] <= req_q.in_byte;
    end
    if (mem_we && wr_addr == rd_addr) begin
      rd_data <= req_q.in_byte;
    end else begin
      rd_data <= block_store[rd_addr];
    end
  end

endmodule

// ===== rtl/core/pattern_data_decompressor_core.sv =====
// Pattern data decompressor: each request carries one command (offer a compressed byte,
// pull a pending output byte, or finish the stream) and produces exactly one response
// with the decoded byte, whether the offered byte was taken, whether replay or zero
// bytes still wait for pulls, and the sticky status. One request is accepted every
// cycle while the response register has room or is being read; each request passes
// the input register, then the parse step that updates the decoder state, then the
// response register, and a new request can enter while the last is parsed. Repeated
// blocks live in a 256-byte store with one write port and one registered read port,
// read one index ahead, so replay pulls are served one per accepted request. The
// store needs no clearing after reset; only bytes loaded by the current block are replayed.
module pattern_data_decompressor_core import pdd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic held_valid;
  req_t held;
  logic space;
  logic fire;
  rsp_t rsp_d;

  assign fire = held_valid && space;

  pdd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .take       (fire),
    .held_valid (held_valid),
    .held       (held)
  );

  pdd_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .req_q (held),
    .rsp_d (rsp_d)
  );

  pdd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .rsp_d     (rsp_d),
    .space     (space),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/core/pdd_checker.sv =====
`include "pattern_data_decompressor_core_macros.svh"

module pdd_checker import pdd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic       fault_seen;
  logic [2:0] fault_last;
  logic       quiet_fields;

  assign quiet_fields = !rsp.out_valid && !rsp.byte_taken && !rsp.more_pending;

  // Remember the first nonzero status delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_seen <= 1'b0;
      fault_last <= ST_RUN;
    end else if (rsp_valid && rsp_ready && rsp.status != ST_RUN && !fault_seen) begin
      fault_seen <= 1'b1;
      fault_last <= rsp.status;
    end
  end

  `PDD_ASSERT_IMP(a_fault_quiet, rsp_valid && rsp.status != ST_RUN, quiet_fields)
  `PDD_ASSERT_IMP(a_idle_byte_zero, rsp_valid && !rsp.out_valid, rsp.out_byte == 8'd0)
  `PDD_ASSERT_IMP(a_status_sticky, rsp_valid && fault_seen, rsp.status == fault_last)
  `PDD_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind pattern_data_decompressor_core pdd_checker u_pdd_checker (.*);

// ===== test/tb_pattern_data_decompressor_core.sv =====
`timescale 1ns / 100ps

module tb_pattern_data_decompressor_core;
  import pdd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] OP_FIRST_BAD = 3'd5;

  typedef enum logic [3:0] {
    AWAIT_OPCODE,
    READ_COUNT,
    READ_ARG1,
    READ_ARG2,
    PASS_LITERAL,
    LOAD_BLOCK,
    PASS_CUSTOM,
    REPLAY_BLOCK,
    EMIT_ZEROS
  } decode_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Decoder state mirrored by the predictor
  decode_phase_t dec_phase = AWAIT_OPCODE;
  logic [2:0] dec_op = '0;
  logic [31:0] dec_len = '0;
  logic [31:0] dec_acc = '0;
  logic [31:0] dec_custom = '0;
  logic [31:0] dec_sections = '0;
  logic [31:0] dec_copies = '0;
  logic [31:0] dec_idx = '0;
  logic [31:0] dec_left = '0;
  logic [2:0] dec_status = ST_RUN;
  logic [7:0] dec_store [BLOCK_DEPTH];

  rsp_t decoded_rsp_q[$];
  rsp_t want_rsp;
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;
  int unsigned stall_left = 0;
  bit idle_on = 1'b1;

  pattern_data_decompressor_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  function automatic logic decoder_pending();
    return dec_status == ST_RUN && (dec_phase == REPLAY_BLOCK || dec_phase == EMIT_ZEROS);
  endfunction

  function automatic void open_zeros();
    if (dec_len == 0) begin
      close_block();
    end else begin
      dec_left = dec_len;
      dec_phase = EMIT_ZEROS;
    end
  endfunction

  function automatic void open_replay();
    dec_idx = 0;
    dec_phase = REPLAY_BLOCK;
  endfunction

  function automatic void close_custom();
    if (dec_op == OP_ZRUN) begin
      open_zeros();
    end else if (dec_len != 0) begin
      dec_copies = 1;
      open_replay();
    end else begin
      close_block();
    end
  endfunction

  function automatic void close_block();
    if ((dec_op == OP_COMMON || dec_op == OP_ZRUN) && dec_sections != 0) begin
      // both pieces empty: drop the remaining sections at once
      if (dec_custom == 0 && dec_len == 0) begin
        dec_sections = 0;
        dec_phase = AWAIT_OPCODE;
        return;
      end
      dec_sections--;
      dec_left = dec_custom;
      if (dec_custom == 0) close_custom();
      else dec_phase = PASS_CUSTOM;
    end else begin
      dec_phase = AWAIT_OPCODE;
    end
  endfunction

  function automatic void close_load();
    if (dec_op == OP_REPEAT && dec_copies != 0 && dec_len != 0) open_replay();
    else close_block();
  endfunction

  function automatic void open_load();
    if (dec_len > DEPTH_LIMIT) begin
      dec_status = ST_TOO_LONG;
      return;
    end
    dec_idx = 0;
    if (dec_len == 0) close_load();
    else dec_phase = LOAD_BLOCK;
  endfunction

  function automatic void start_op();
    case (dec_op)
      OP_ZERO: open_zeros();
      OP_LITERAL: begin
        dec_left = dec_len;
        dec_phase = (dec_len == 0) ? AWAIT_OPCODE : PASS_LITERAL;
      end
      default: begin
        dec_acc = 0;
        dec_phase = READ_ARG1;
      end
    endcase
  endfunction

  // Returns {valid, byte} for an offered byte that was taken
  function automatic logic [8:0] consume_byte(input logic [7:0] b);
    logic [31:0] v;
    case (dec_phase)
      AWAIT_OPCODE: begin
        if (b[7:5] > OP_ZRUN) begin
          dec_status = ST_BAD_OP;
          return 9'd0;
        end
        dec_op = b[7:5];
        dec_sections = 0;
        dec_copies = 0;
        if (b[4:0] == 5'd0) begin
          dec_acc = 0;
          dec_phase = READ_COUNT;
        end else begin
          dec_len = 32'(b[4:0]);
          start_op();
        end
      end
      READ_COUNT, READ_ARG1, READ_ARG2: begin
        dec_acc = {dec_acc[24:0], b[6:0]};
        if (!b[7]) begin
          v = dec_acc;
          dec_acc = 0;
          if (dec_phase == READ_COUNT) begin
            dec_len = v;
            start_op();
          end else if (dec_phase == READ_ARG1) begin
            if (dec_op == OP_REPEAT) begin
              dec_copies = v;
              open_load();
            end else begin
              dec_custom = v;
              dec_phase = READ_ARG2;
            end
          end else begin
            dec_sections = v;
            if (dec_op == OP_COMMON) open_load();
            else open_zeros();
          end
        end
      end
      PASS_LITERAL, PASS_CUSTOM: begin
        dec_left--;
        if (dec_left == 0) begin
          if (dec_phase == PASS_LITERAL) dec_phase = AWAIT_OPCODE;
          else close_custom();
        end
        return {1'b1, b};
      end
      LOAD_BLOCK: begin
        dec_store[dec_idx[ADDR_W-1:0]] = b;
        dec_idx++;
        if (dec_idx >= dec_len) close_load();
        return {1'b1, b};
      end
      default: ;
    endcase
    return 9'd0;
  endfunction

  function automatic logic [8:0] pull_byte();
    logic [7:0] b;
    if (dec_phase == EMIT_ZEROS) begin
      dec_left--;
      if (dec_left == 0) close_block();
      return {1'b1, 8'h00};
    end
    if (dec_phase == REPLAY_BLOCK) begin
      b = dec_store[dec_idx[ADDR_W-1:0]];
      dec_idx++;
      if (dec_idx >= dec_len) begin
        dec_idx = 0;
        dec_copies--;
        if (dec_copies == 0) close_block();
      end
      return {1'b1, b};
    end
    return 9'd0;
  endfunction

  function automatic rsp_t decode_step(input req_t r);
    rsp_t e;
    logic [8:0] emitted;
    logic busy;
    e = '0;
    emitted = '0;
    busy = decoder_pending();
    if (dec_status == ST_RUN) begin
      case (r.command)
        CMD_OFFER: begin
          if (!busy) begin
            e.byte_taken = 1'b1;
            emitted = consume_byte(r.in_byte);
          end
        end
        CMD_PULL: emitted = pull_byte();
        CMD_FINISH: begin
          if (!busy) dec_status = (dec_phase == AWAIT_OPCODE) ? ST_DONE : ST_TRUNC;
        end
        default: ;
      endcase
    end
    if (dec_status == ST_RUN) begin
      {e.out_valid, e.out_byte} = emitted;
      e.more_pending = decoder_pending();
    end else begin
      e = '0;
    end
    e.status = dec_status;
    return e;
  endfunction

  task automatic send_cmd(input logic [1:0] command, input logic [7:0] data);
    req_t item;
    item.command = command;
    item.in_byte = data;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    decoded_rsp_q.push_back(decode_step(item));
    sent_count++;
  endtask

  // Big-endian 7-bit groups; optional leading groups and bits above 32 wrap away
  task automatic send_varint(input logic [31:0] value);
    logic [34:0] ext;
    logic [6:0] grp;
    int groups;
    int total;
    bit junk;
    groups = 1;
    while (groups < 5 && (value >> (7 * groups)) != 0) groups++;
    total = groups + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
    junk = 1'($urandom_range(0, 1));
    ext = {(junk ? 3'($urandom) : 3'd0), value};
    for (int p = total - 1; p >= 0; p--) begin
      if (p < 5) grp = ext[7*p +: 7];
      else grp = junk ? 7'($urandom) : 7'd0;
      send_cmd(CMD_OFFER, {p != 0, grp});
    end
  endtask

  task automatic test_literal_wrap();
    // count varint overflows 32 bits and lands on 2
    send_cmd(CMD_OFFER, {OP_LITERAL, 5'd0});
    send_cmd(CMD_OFFER, 8'h90);
    send_cmd(CMD_OFFER, 8'h80);
    send_cmd(CMD_OFFER, 8'h80);
    send_cmd(CMD_OFFER, 8'h80);
    send_cmd(CMD_OFFER, 8'h02);
    send_cmd(CMD_OFFER, 8'h00);
    send_cmd(CMD_OFFER, 8'hFF);
  endtask

  task automatic test_zero_fill();
    send_cmd(CMD_OFFER, {OP_ZERO, 5'd1});
    send_cmd(CMD_OFFER, 8'h3C);
    send_cmd(CMD_FINISH, 8'h00);
    send_cmd(CMD_UNUSED, 8'hFF);
    send_cmd(CMD_PULL, 8'h00);
    send_cmd(CMD_PULL, 8'h00);
  endtask

  task automatic test_repeat_block();
    send_cmd(CMD_OFFER, {OP_REPEAT, 5'd1});
    send_cmd(CMD_OFFER, 8'h01);
    send_cmd(CMD_OFFER, 8'h5A);
    send_cmd(CMD_PULL, 8'h00);
  endtask

  task automatic test_common_block();
    send_cmd(CMD_OFFER, {OP_COMMON, 5'd1});
    send_cmd(CMD_OFFER, 8'h01);
    send_cmd(CMD_OFFER, 8'h01);
    send_cmd(CMD_OFFER, 8'h11);
    send_cmd(CMD_OFFER, 8'h22);
    send_cmd(CMD_PULL, 8'h00);
  endtask

  task automatic test_section_drop();
    send_cmd(CMD_OFFER, {OP_ZRUN, 5'd0});
    send_cmd(CMD_OFFER, 8'h00);
    send_cmd(CMD_OFFER, 8'h00);
    send_cmd(CMD_OFFER, 8'h85);
    send_cmd(CMD_OFFER, 8'h00);
  endtask

  task automatic run_random_instruction();
    logic [2:0] op;
    logic [31:0] len;
    logic [31:0] reps;
    logic [31:0] custom;
    logic [31:0] sections;
    int unsigned pick;
    op = 3'($urandom_range(OP_ZERO, OP_ZRUN));
    pick = $urandom_range(0, 24);
    case (op)
      OP_REPEAT, OP_COMMON: begin
        if (pick == 0) len = DEPTH_LIMIT;
        else if (pick == 1) len = $urandom_range(100, 255);
        else if (pick <= 4) len = 0;
        else len = $urandom_range(1, 16);
      end
      OP_LITERAL: len = (pick == 0) ? 0 : (pick == 1) ? 40 : $urandom_range(1, 31);
      default: begin
        if (pick == 0) len = 0;
        else if (pick == 1) len = $urandom_range(200, 300);
        else len = $urandom_range(1, 12);
      end
    endcase
    reps = (len > 32) ? $urandom_range(0, 1) : $urandom_range(0, 3);
    custom = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
    sections = $urandom_range(0, 3);
    if (custom == 0 && len == 0 && $urandom_range(0, 1) == 1) sections = $urandom;

    if (len != 0 && len < 32 && $urandom_range(0, 3) != 0) begin
      send_cmd(CMD_OFFER, {op, len[4:0]});
    end else begin
      send_cmd(CMD_OFFER, {op, 5'd0});
      send_varint(len);
    end
    if (op == OP_REPEAT) begin
      send_varint(reps);
    end else if (op == OP_COMMON || op == OP_ZRUN) begin
      send_varint(custom);
      send_varint(sections);
    end

    // feed data bytes and drain output until the next opcode is due
    while (dec_status == ST_RUN && dec_phase != AWAIT_OPCODE) begin
      if (decoder_pending()) begin
        pick = $urandom_range(0, 11);
        if (pick == 0) send_cmd(CMD_OFFER, 8'($urandom));
        else if (pick == 1) send_cmd(CMD_FINISH, 8'($urandom));
        else if (pick == 2) send_cmd(CMD_UNUSED, 8'($urandom));
        else send_cmd(CMD_PULL, 8'($urandom));
      end else if ($urandom_range(0, 24) == 0) begin
        send_cmd(CMD_PULL, 8'($urandom));
      end else begin
        send_cmd(CMD_OFFER, 8'($urandom));
      end
    end
  endtask

  task automatic test_random_stream();
    int unsigned start;
    start = sent_count;
    idle_on = 1'b1;
    while (sent_count - start < RANDOM_ITEMS) begin
      if (sent_count - start > RANDOM_ITEMS - 100) idle_on = 1'b0;
      else if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 9) == 0)
        send_cmd(($urandom_range(0, 1) == 1) ? CMD_PULL : CMD_UNUSED, 8'($urandom));
      run_random_instruction();
    end
  endtask

  // Status is sticky until reset, so only one way of ending is taken per run
  task automatic test_sticky_status();
    int unsigned kind;
    logic [31:0] len;
    idle_on = 1'b0;
    kind = $urandom_range(0, 4);
    case (kind)
      0: send_cmd(CMD_FINISH, 8'($urandom));
      1: begin
        send_cmd(CMD_OFFER, {OP_LITERAL, 5'd0});
        send_cmd(CMD_FINISH, 8'($urandom));
      end
      2: send_cmd(CMD_OFFER, {OP_FIRST_BAD + 3'($urandom_range(0, 2)), 5'($urandom)});
      3: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(32'hFFFF_FFFF, DEPTH_LIMIT + 1)
                                          : DEPTH_LIMIT + 1;
        if ($urandom_range(0, 1) == 1) begin
          send_cmd(CMD_OFFER, {OP_REPEAT, 5'd0});
          send_varint(len);
          send_varint($urandom_range(0, 3));
        end else begin
          send_cmd(CMD_OFFER, {OP_COMMON, 5'd0});
          send_varint(len);
          send_varint($urandom_range(0, 3));
          send_varint($urandom_range(0, 3));
        end
      end
      default: begin
        // all-ones repeat count: the replay never runs dry within the run
        send_cmd(CMD_OFFER, {OP_REPEAT, 5'd1});
        send_varint(32'hFFFF_FFFF);
        send_cmd(CMD_OFFER, 8'($urandom));
        repeat (40) send_cmd(CMD_PULL, 8'($urandom));
      end
    endcase
    repeat (6) send_cmd(2'($urandom), 8'($urandom));
  endtask

  // Stall bursts on the response side
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      rsp_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      rsp_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (decoded_rsp_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: response with no request outstanding, status %0d", $time, rsp.status);
        mismatch_count++;
      end else begin
        want_rsp = decoded_rsp_q.pop_front();
        if (rsp.out_valid !== want_rsp.out_valid || rsp.out_byte !== want_rsp.out_byte ||
            rsp.byte_taken !== want_rsp.byte_taken ||
            rsp.more_pending !== want_rsp.more_pending || rsp.status !== want_rsp.status) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: expected valid %0b byte %02h taken %0b more %0b status %0d, %s",
                     $time, want_rsp.out_valid, want_rsp.out_byte, want_rsp.byte_taken,
                     want_rsp.more_pending, want_rsp.status,
                     $sformatf("got valid %0b byte %02h taken %0b more %0b status %0d",
                               rsp.out_valid, rsp.out_byte, rsp.byte_taken,
                               rsp.more_pending, rsp.status));
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_literal_wrap();
    test_zero_fill();
    test_repeat_block();
    test_common_block();
    test_section_drop();
    test_random_stream();
    test_sticky_status();
    req_valid <= 1'b0;
    while (decoded_rsp_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
